@@ design/srms_pkg.sv @@
// ============================================================================
// srms_pkg: shared types for the split running mean / stddev core
// Controller states, controller-to-datapath commands and datapath status.
// ============================================================================
package srms_pkg;

  localparam logic [15:0] SPLIT_TICK_RESET = 16'd100;
  localparam int          OUT_W            = 16;
  localparam int          MEAN_W           = 32;
  localparam int          M2_W             = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_WAIT_MEAN,
    ST_CALC_B,
    ST_MUL,
    ST_ACC,
    ST_SPLIT_CHK,
    ST_SP_DIV,
    ST_SP_SQRT,
    ST_LAST_CHK,
    ST_LT_DIV,
    ST_LT_SQRT,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;      // load sample, bump counters, form delta
    logic div_start;   // start shared divider
    logic div_wide;    // 1: M2 / count, 0: |delta| / count
    logic mean_upd;    // apply quotient to running mean
    logic calc_b;      // second deviation factor
    logic mul;         // deviation product
    logic acc;         // saturating M2 accumulate
    logic sqrt_start;  // start square root on divider quotient
    logic latch_first; // latch first-phase stats, clear accumulators
    logic emit;        // load result register, clear run
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic split_hit;
    logic last;
    logic cnt_zero;
    logic out_free;
  } ctrl_sts_t;

endpackage

@@ design/srms_div.sv @@
// ============================================================================
// srms_div: iterative restoring divider
// One quotient bit per cycle; 32 or 64 steps. Quotient is 64 bits.
// ============================================================================
module srms_div #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  wide,
  input  logic [63:0]           dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic [63:0]           quotient,
  output logic                  done
);

  logic                  busy_r;
  logic                  done_r;
  logic [5:0]            step_r;
  logic [63:0]           quo_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [COUNT_BITS-1:0] dsr_r;

  logic [COUNT_BITS:0]   rem_sh;
  logic                  ge;
  logic [COUNT_BITS:0]   diff;

  assign rem_sh = {rem_r, quo_r[63]};
  assign ge     = rem_sh >= {1'b0, dsr_r};
  assign diff   = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= wide ? dividend : {dividend[31:0], 32'd0};
      step_r <= wide ? 6'd63 : 6'd31;
      rem_r  <= '0;
      dsr_r  <= divisor;
    end else if (busy_r) begin
      quo_r  <= {quo_r[62:0], ge};
      rem_r  <= ge ? diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
      step_r <= step_r - 6'd1;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

@@ design/srms_sqrt.sv @@
// ============================================================================
// srms_sqrt: digit-by-digit integer square root
// Two radicand bits per cycle for a 64-bit radicand.
// ============================================================================
module srms_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  step_r;
  logic [63:0] rad_r;
  logic [31:0] root_r;
  logic [32:0] rem_r;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;
  logic [34:0] diff;

  assign rem_sh = {rem_r, rad_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // remainder stays below 2*root+1, so 33 bits hold it
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      root_r <= '0;
      rem_r  <= '0;
      step_r <= 5'd31;
    end else if (busy_r) begin
      rad_r  <= {rad_r[61:0], 2'b00};
      root_r <= {root_r[30:0], ge};
      rem_r  <= ge ? diff[32:0] : rem_sh[32:0];
      step_r <= step_r - 5'd1;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

@@ design/srms_ctrl.sv @@
// ============================================================================
// srms_ctrl: sequencing controller
// Steps one sample through mean update, M2 update, split and end-of-run.
// ============================================================================
module srms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srms_pkg::ctrl_sts_t sts,
  output srms_pkg::ctrl_cmd_t cmd
);

  srms_pkg::ctrl_state_t state_r;
  srms_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      srms_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = srms_pkg::ST_DIV_MEAN;
        end
      end
      srms_pkg::ST_DIV_MEAN: begin
        cmd.div_start = 1'b1;
        state_nxt     = srms_pkg::ST_WAIT_MEAN;
      end
      srms_pkg::ST_WAIT_MEAN: begin
        if (sts.div_done) begin
          cmd.mean_upd = 1'b1;
          state_nxt    = srms_pkg::ST_CALC_B;
        end
      end
      srms_pkg::ST_CALC_B: begin
        cmd.calc_b = 1'b1;
        state_nxt  = srms_pkg::ST_MUL;
      end
      srms_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = srms_pkg::ST_ACC;
      end
      srms_pkg::ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = srms_pkg::ST_SPLIT_CHK;
      end
      srms_pkg::ST_SPLIT_CHK: begin
        if (sts.split_hit) begin
          cmd.div_start = 1'b1;
          cmd.div_wide  = 1'b1;
          state_nxt     = srms_pkg::ST_SP_DIV;
        end else begin
          state_nxt = srms_pkg::ST_LAST_CHK;
        end
      end
      srms_pkg::ST_SP_DIV: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = srms_pkg::ST_SP_SQRT;
        end
      end
      srms_pkg::ST_SP_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.latch_first = 1'b1;
          state_nxt       = srms_pkg::ST_LAST_CHK;
        end
      end
      srms_pkg::ST_LAST_CHK: begin
        if (!sts.last) begin
          state_nxt = srms_pkg::ST_IDLE;
        end else if (sts.cnt_zero) begin
          state_nxt = srms_pkg::ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_wide  = 1'b1;
          state_nxt     = srms_pkg::ST_LT_DIV;
        end
      end
      srms_pkg::ST_LT_DIV: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = srms_pkg::ST_LT_SQRT;
        end
      end
      srms_pkg::ST_LT_SQRT: begin
        if (sts.sqrt_done) begin
          state_nxt = srms_pkg::ST_EMIT;
        end
      end
      srms_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = srms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srms_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/srms_dp.sv @@
// ============================================================================
// srms_dp: statistics datapath
// Welford accumulators, split latch, shared divider and square root, result
// register.
// ============================================================================
module srms_dp #(
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  srms_pkg::ctrl_cmd_t            cmd,
  output srms_pkg::ctrl_sts_t            sts,
  input  logic                           cfg_valid,
  input  logic [15:0]                    cfg_split_tick,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  input  logic                           in_last_tick,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [srms_pkg::OUT_W-1:0] out_first_mean,
  output logic [srms_pkg::OUT_W-1:0]     out_first_stddev,
  output logic signed [srms_pkg::OUT_W-1:0] out_last_mean,
  output logic [srms_pkg::OUT_W-1:0]     out_last_stddev
);

  localparam int MEAN_SHIFT = srms_pkg::MEAN_W - SAMPLE_BITS;
  localparam int INC_SHIFT  = srms_pkg::M2_W - 2 * SAMPLE_BITS;
  localparam int CMP_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // run state
  logic [15:0]                       split_r;
  logic [COUNT_BITS-1:0]             tick_r;
  logic [COUNT_BITS-1:0]             cnt_r;
  logic signed [31:0]                mean_r;
  logic [63:0]                       m2_r;
  logic [15:0]                       lfm_r;
  logic [15:0]                       lfs_r;
  logic                              adv_r;
  logic                              last_r;
  logic                              out_valid_r;

  // per-sample working registers
  logic signed [31:0]                x31_r;
  logic [31:0]                       a_r;
  logic                              dneg_r;
  logic                              dzero_r;
  logic [31:0]                       b_r;
  logic [63:0]                       prod_r;

  logic [15:0] ofm_r, ofs_r, olm_r, ols_r;

  // combinational helpers
  logic signed [31:0] x31;
  logic signed [32:0] delta;
  logic [32:0]        delta_mag;
  logic [31:0]        quo_lo;
  logic signed [33:0] q_s;
  logic signed [33:0] nm;
  logic signed [31:0] nm_clamp;
  logic signed [32:0] delta2;
  logic [32:0]        delta2_mag;
  logic [63:0]        inc;
  logic [64:0]        m2_sum;
  logic signed [31:0] mean_sh;
  logic [15:0]        mean16;
  logic [15:0]        std16;
  logic [15:0]        std_cur;
  logic               split_hit;
  logic               before_split;

  logic [63:0] div_q;
  logic        div_done;
  logic [31:0] root;
  logic        sqrt_done;

  srms_div #(.COUNT_BITS(COUNT_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .wide     (cmd.div_wide),
    .dividend (cmd.div_wide ? m2_r : {32'd0, a_r}),
    .divisor  (cnt_r),
    .quotient (div_q),
    .done     (div_done)
  );

  srms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (div_q),
    .root     (root),
    .done     (sqrt_done)
  );

  // sample aligned to Q1.31
  assign x31       = 32'(in_sample) <<< MEAN_SHIFT;
  assign delta     = 33'(x31) - 33'(mean_r);
  assign delta_mag = delta[32] ? -delta : delta;

  // mean step: quotient truncated toward zero, sign of delta
  assign quo_lo   = div_q[31:0];
  assign q_s      = dneg_r ? -$signed({2'b00, quo_lo}) : $signed({2'b00, quo_lo});
  assign nm       = 34'(mean_r) + q_s;
  always_comb begin
    if (nm[33:31] == 3'b000 || nm[33:31] == 3'b111) begin
      nm_clamp = nm[31:0];
    end else if (nm[33]) begin
      nm_clamp = 32'sh8000_0000;
    end else begin
      nm_clamp = 32'sh7fff_ffff;
    end
  end

  // second factor uses the updated mean
  assign delta2     = 33'(x31_r) - 33'(mean_r);
  assign delta2_mag = delta2[32] ? -delta2 : delta2;

  assign inc    = prod_r >> INC_SHIFT;
  assign m2_sum = {1'b0, m2_r} + {1'b0, inc};

  assign mean_sh = mean_r >>> MEAN_SHIFT;
  assign mean16  = mean_sh[15:0];
  assign std16   = (root[31:16] != 16'd0) ? 16'hffff : root[15:0];
  assign std_cur = (cnt_r == '0) ? 16'd0 : std16;

  assign split_hit    = adv_r && (CMP_W'(tick_r) == CMP_W'(split_r));
  assign before_split = CMP_W'(tick_r) < CMP_W'(split_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r <= srms_pkg::SPLIT_TICK_RESET;
    end else if (cfg_valid) begin
      split_r <= cfg_split_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      cnt_r  <= '0;
      mean_r <= '0;
      m2_r   <= '0;
      lfm_r  <= '0;
      lfs_r  <= '0;
      adv_r  <= 1'b0;
      last_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        adv_r  <= tick_r != CNT_MAX;
        last_r <= in_last_tick;
        if (tick_r != CNT_MAX) tick_r <= tick_r + 1'b1;
        if (cnt_r != CNT_MAX) cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.mean_upd) begin
        mean_r <= nm_clamp;
      end
      if (cmd.acc) begin
        m2_r <= m2_sum[64] ? '1 : m2_sum[63:0];
      end
      if (cmd.latch_first) begin
        lfm_r  <= mean16;
        lfs_r  <= std16;
        cnt_r  <= '0;
        mean_r <= '0;
        m2_r   <= '0;
      end
      if (cmd.emit) begin
        tick_r <= '0;
        cnt_r  <= '0;
        mean_r <= '0;
        m2_r   <= '0;
        lfm_r  <= '0;
        lfs_r  <= '0;
      end
    end
  end

  // |delta| never exceeds 2^32 - 1, so the low 32 bits carry it
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x31_r   <= x31;
      a_r     <= delta_mag[31:0];
      dneg_r  <= delta[32];
      dzero_r <= delta == '0;
    end
    if (cmd.calc_b) begin
      if (dneg_r != delta2[32] && delta2 != '0 && !dzero_r) begin
        b_r <= '0;
      end else begin
        b_r <= delta2_mag[31:0];
      end
    end
    if (cmd.mul) begin
      prod_r <= a_r * b_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (before_split) begin
        ofm_r <= mean16;
        ofs_r <= std_cur;
        olm_r <= '0;
        ols_r <= '0;
      end else begin
        ofm_r <= lfm_r;
        ofs_r <= lfs_r;
        olm_r <= mean16;
        ols_r <= std_cur;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_mean   = ofm_r;
  assign out_first_stddev = ofs_r;
  assign out_last_mean    = olm_r;
  assign out_last_stddev  = ols_r;

  always_comb begin
    sts.div_done  = div_done;
    sts.sqrt_done = sqrt_done;
    sts.split_hit = split_hit;
    sts.last      = last_r;
    sts.cnt_zero  = cnt_r == '0;
    sts.out_free  = !out_valid_r || !out_stall;
  end

endmodule

@@ design/split_running_mean_stddev_core.sv @@
// ============================================================================
// split_running_mean_stddev_core: two-phase running mean and stddev
// Welford statistics over a run of samples, split at a configured tick.
// ============================================================================
// One sample is taken per transfer on the in_ channel. Each sample updates a
// Welford count, Q1.31 mean and saturating M2. When the tick count reaches
// split_tick the first-phase mean and population stddev are latched and the
// accumulators restart; a sample flagged last_tick returns one result on the
// out_ channel (first and last phase, Q1.15) and clears the run. A plain
// sample is held mostly by the 32-step bit-serial divide of the mean update. A
// sample that splits adds a 64-step divide of M2 by the count and a 32-step
// square root on the same shared units; one that ends the run adds the same,
// unless a split on that sample has just emptied the accumulators, plus any
// wait for the output register. The block takes one sample at a time (in_stall is
// high while it works), and a finished result waits in the output register,
// so the next sample can start before the result is taken. split_tick resets
// to 100 and is written at any time through the cfg_ channel (cfg_ready is
// always high); write it only while the block is idle.
module split_running_mean_stddev_core #(
  parameter int COUNT_BITS  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last_tick,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_first_mean,
  output logic [15:0]                   out_first_stddev,
  output logic signed [15:0]            out_last_mean,
  output logic [15:0]                   out_last_stddev,
  // split tick register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [15:0]                   cfg_split_tick
);

  srms_pkg::ctrl_cmd_t cmd;
  srms_pkg::ctrl_sts_t sts;

  // register write never back-pressures
  assign cfg_ready = 1'b1;

  srms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  srms_dp #(
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_split_tick   (cfg_split_tick),
    .in_sample        (in_sample),
    .in_last_tick     (in_last_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_mean   (out_first_mean),
    .out_first_stddev (out_first_stddev),
    .out_last_mean    (out_last_mean),
    .out_last_stddev  (out_last_stddev)
  );

endmodule

@@ design/srms_checker.sv @@
// ============================================================================
// srms_checker: port-level checks for the split mean / stddev core
// Result hold under stall, one sample at a time, result only after work.
// ============================================================================
module srms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_first_mean,
  input logic [15:0] out_first_stddev,
  input logic [15:0] out_last_mean,
  input logic [15:0] out_last_stddev
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_first_mean) &&
      $stable(out_first_stddev) && $stable(out_last_mean) && $stable(out_last_stddev))
    else $error("stalled result changed");

  // a taken sample keeps the input closed for the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // a new result only appears while a sample is in work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without sample in work");

endmodule

bind split_running_mean_stddev_core srms_checker u_srms_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_first_mean   (out_first_mean),
  .out_first_stddev (out_first_stddev),
  .out_last_mean    (out_last_mean),
  .out_last_stddev  (out_last_stddev)
);

@@ dv/srms_stats_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// srms_stats_checker: result checker for the split mean / stddev core
// Watches the sample, result and split tick channels, predicts the two-phase
// Welford statistics of every run and compares each result transfer in order.
// ============================================================================
module srms_stats_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_sample,
  input  logic               in_last_tick,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_first_mean,
  input  logic [15:0]        out_first_stddev,
  input  logic signed [15:0] out_last_mean,
  input  logic [15:0]        out_last_stddev,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_split_tick,
  output int                 fail_count,
  output int                 pending
);

  localparam longint unsigned CNT_MAX  = 64'd65535;
  localparam longint          MEAN_MAX = 64'sd2147483647;
  localparam longint          MEAN_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [15:0] first_mean;
    logic [15:0]        first_stddev;
    logic signed [15:0] last_mean;
    logic [15:0]        last_stddev;
  } phase_stats_t;

  phase_stats_t    expected_stats[$];
  phase_stats_t    got, want, res;
  bit              has_res;

  // predicted state of the block
  logic [15:0]     split_q;
  longint unsigned sample_cnt, tick_cnt;
  longint          run_mean;           // Q1.31
  logic [63:0]     sq_dev_sum;         // M2, sample LSB squared
  logic [15:0]     first_mean_q, first_sd_q;

  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] r, t;
    int          i;
    r = '0;
    for (i = 31; i >= 0; i--) begin
      t = r | (32'd1 << i);
      if ({32'd0, t} * {32'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [15:0] mean_q15(input longint m);
    longint t;
    t = m >>> 16;  // floor
    return t[15:0];
  endfunction

  function automatic logic [15:0] stddev_q15(input logic [63:0] m2,
                                             input longint unsigned n);
    logic [31:0] r;
    if (n == 0) return 16'd0;
    r = floor_sqrt(m2 / n);
    if (r > 32'hFFFF) r = 32'hFFFF;
    return r[15:0];
  endfunction

  task automatic clear_accum();
    sample_cnt = 0;
    run_mean   = 0;
    sq_dev_sum = '0;
  endtask

  task automatic clear_run();
    clear_accum();
    tick_cnt     = 0;
    first_mean_q = '0;
    first_sd_q   = '0;
  endtask

  task automatic step_welford(input logic signed [15:0] smp, input logic last,
                              output bit produced, output phase_stats_t stats);
    longint      xs, x31, delta, delta2, nm;
    logic [63:0] a, b, prod, inc;
    bit          advanced;
    xs       = smp;
    x31      = xs * 65536;
    advanced = 0;
    produced = 0;
    stats    = '0;
    if (tick_cnt < CNT_MAX) begin
      tick_cnt++;
      advanced = 1;
    end
    if (sample_cnt < CNT_MAX) sample_cnt++;

    delta = x31 - run_mean;
    nm    = run_mean + delta / longint'(sample_cnt);
    if (nm > MEAN_MAX) nm = MEAN_MAX;
    if (nm < MEAN_MIN) nm = MEAN_MIN;
    run_mean = nm;
    delta2   = x31 - nm;

    // both deviation factors share a sign unless one of them is zero
    a = (delta < 0) ? -delta : delta;
    b = (delta2 < 0) ? -delta2 : delta2;
    if (((delta < 0) != (delta2 < 0)) && delta != 0 && delta2 != 0) b = '0;
    prod = a * b;
    inc  = prod >> 32;
    if (sq_dev_sum > ~64'd0 - inc) sq_dev_sum = ~64'd0;
    else sq_dev_sum = sq_dev_sum + inc;

    if (advanced && tick_cnt == split_q) begin
      first_mean_q = mean_q15(run_mean);
      first_sd_q   = stddev_q15(sq_dev_sum, sample_cnt);
      clear_accum();
    end

    if (last) begin
      produced = 1;
      if (tick_cnt < split_q) begin
        stats.first_mean   = mean_q15(run_mean);
        stats.first_stddev = stddev_q15(sq_dev_sum, sample_cnt);
      end else begin
        stats.first_mean   = first_mean_q;
        stats.first_stddev = first_sd_q;
        stats.last_mean    = mean_q15(run_mean);
        stats.last_stddev  = stddev_q15(sq_dev_sum, sample_cnt);
      end
      clear_run();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      split_q = srms_pkg::SPLIT_TICK_RESET;
      clear_run();
      expected_stats.delete();
      fail_count = 0;
    end else begin
      // results first: a result never belongs to a sample taken at this edge
      if (out_valid && !out_stall) begin
        got = {out_first_mean, out_first_stddev, out_last_mean, out_last_stddev};
        if (expected_stats.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("%0t: unexpected result fm=%0d fs=%0d lm=%0d ls=%0d", $realtime,
                     got.first_mean, got.first_stddev, got.last_mean, got.last_stddev);
        end else begin
          want = expected_stats.pop_front();
          if (got !== want) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("%0t: mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       $realtime, want.first_mean, want.first_stddev, want.last_mean,
                       want.last_stddev, got.first_mean, got.first_stddev,
                       got.last_mean, got.last_stddev);
          end
        end
      end
      if (in_valid && !in_stall) begin
        step_welford(in_sample, in_last_tick, has_res, res);
        if (has_res) expected_stats = {expected_stats, res};
      end
      if (cfg_valid && cfg_ready) split_q = cfg_split_tick;
    end
    pending <= expected_stats.size();
  end

endmodule

@@ dv/tb_split_running_mean_stddev_core.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_split_running_mean_stddev_core: testbench for the split stats core
// Directed runs around the split tick, then random runs under several split
// settings, with random gaps on the sample side and stalls on the result side.
// ============================================================================
module tb_split_running_mean_stddev_core;

  // This covers the longest work, a sample that splits or ends a run,
  // with margin before a split tick write.
  localparam int DRAIN_CYCLES   = 200;
  // Cycles without any transfer before the run is declared hung. Worst
  // legit quiet stretch: drain + one long item + longest result stall.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_PHASES     = 8;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_sample      = '0;
  logic               in_last_tick   = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic signed [15:0] out_first_mean;
  logic [15:0]        out_first_stddev;
  logic signed [15:0] out_last_mean;
  logic [15:0]        out_last_stddev;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_split_tick = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int stall_run   = 0;
  bit quiet       = 0;   // phase with back-to-back samples

  // split settings for the random phases; the last one is drawn at run time
  int split_plan [0:NUM_PHASES-1] = '{5, 1, 65535, 2, 100, 17, 0, 0};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  split_running_mean_stddev_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_last_tick     (in_last_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_mean   (out_first_mean),
    .out_first_stddev (out_first_stddev),
    .out_last_mean    (out_last_mean),
    .out_last_stddev  (out_last_stddev),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_split_tick   (cfg_split_tick)
  );

  srms_stats_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_last_tick     (in_last_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_mean   (out_first_mean),
    .out_first_stddev (out_first_stddev),
    .out_last_mean    (out_last_mean),
    .out_last_stddev  (out_last_stddev),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_split_tick   (cfg_split_tick),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Result-side backpressure: segments of free flow, short stalls and the
  // odd long stall, so a finished result waits in every phase of the next
  // sample's processing.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          out_stall <= 1'b0;
          stall_run <= $urandom_range(1, 25);
        end
        6, 7, 8: begin
          out_stall <= 1'b1;
          stall_run <= $urandom_range(1, 4);
        end
        default: begin
          out_stall <= 1'b1;
          stall_run <= $urandom_range(20, 80);
        end
      endcase
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // style 0: full-range noise, 1: full-scale extremes, 2: small noise around
  // a level (low stddev). One sample in ten is full-range regardless.
  function automatic logic signed [15:0] draw_sample(input int style,
                                                     input logic signed [15:0] level);
    int v;
    if (style == 0 || $urandom_range(0, 9) == 0) begin
      v = $urandom;
      return v[15:0];
    end
    if (style == 1) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    v = int'(level) + int'($urandom_range(0, 64)) - 32;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // One sample transfer. Valid is held until the transfer; a gap drops it
  // first, so valid never rises and falls in the same step.
  task automatic send_tick(input logic signed [15:0] smp, input logic last);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample    <= smp;
    in_last_tick <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_run(input int len);
    int                 k, style;
    logic signed [15:0] level;
    style = $urandom_range(0, 2);
    level = 16'($urandom);
    for (k = 0; k < len; k++) send_tick(draw_sample(style, level), k == len - 1);
  endtask

  // Wait until every result is back and the core has gone quiet.
  // The first edge lets the checker's count catch up with the last transfer.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_split(input logic [15:0] value);
    cfg_valid      <= 1'b1;
    cfg_split_tick <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Runs are sized against the split: some end short of it, some right on
  // it, most run past it. Splits that runs cannot reach get short runs.
  task automatic random_phase(input logic [15:0] split, input int budget);
    int sent, len, kind;
    settle();
    write_split(split);
    quiet = ($urandom_range(0, 3) == 0);
    sent  = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 9);
      if (split == 0 || split > 200) len = $urandom_range(1, 60);
      else if (kind < 2 && split > 1) len = $urandom_range(1, split - 1);
      else if (kind < 4) len = int'(split);
      else len = int'(split) + int'($urandom_range(1, 60));
      send_run(len);
      sent += len;
    end
  endtask

  initial begin
    int p;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset split of 100: a short run ends before the split
    send_tick(16'sh7FFF, 1'b0);
    send_tick(16'sh8000, 1'b1);

    // split at tick 3
    settle();
    write_split(16'd3);
    send_tick(16'sh7FFF, 1'b0);   // run past the split, extremes both sides
    send_tick(16'sh8000, 1'b0);
    send_tick(16'sh7FFF, 1'b0);
    send_tick(16'sh8000, 1'b0);
    send_tick(16'sh0000, 1'b1);
    send_tick(16'sh8000, 1'b1);   // one-tick run, before the split
    send_tick(16'sh0005, 1'b0);   // run ending on the split tick
    send_tick(-16'sh0005, 1'b0);
    send_tick(16'sh0064, 1'b1);

    // split at tick 1
    settle();
    write_split(16'd1);
    send_tick(16'sh7FFF, 1'b1);   // split and end on the same tick
    send_tick(16'sh8000, 1'b0);   // constant minimum after the split
    send_tick(16'sh8000, 1'b0);
    send_tick(16'sh8000, 1'b0);
    send_tick(16'sh8000, 1'b1);

    // split tick zero: never splits, whole run lands in the last phase
    settle();
    write_split(16'd0);
    send_tick(16'sh0001, 1'b0);
    send_tick(-16'sh0001, 1'b0);
    send_tick(16'sh7FFF, 1'b1);

    split_plan[NUM_PHASES-1] = $urandom_range(3, 40);
    for (p = 0; p < NUM_PHASES; p++) random_phase(16'(split_plan[p]), 180);

    settle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/srms_pkg.sv
design/srms_div.sv
design/srms_sqrt.sv
design/srms_ctrl.sv
design/srms_dp.sv
design/split_running_mean_stddev_core.sv
design/srms_checker.sv
dv/srms_stats_checker.sv
dv/tb_split_running_mean_stddev_core.sv
